[design/swgm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swgm_pkg
// Shared types and gas constants for the storage write gas meter.
// ----------------------------------------------------------------------------
package swgm_pkg;

   // rule set selected by the fork_era register
   typedef enum logic [1:0] {
      ERA_PRE_ISTANBUL = 2'd0,
      ERA_ISTANBUL     = 2'd1,
      ERA_BERLIN       = 2'd2,
      ERA_LONDON       = 2'd3
   } era_type;

   // flag vectors: zero bit0 current, bit1 original, bit2 new
   // equal bit0 current==new, bit1 original==current, bit2 original==new
   typedef struct packed {
      logic [2:0] zero;
      logic [2:0] equal;
   } flags_type;

   localparam logic [2:0] FLAGS_ALL = 3'b111;

   // gas amounts
   localparam logic [14:0] GAS_SET           = 15'd20000;
   localparam logic [14:0] GAS_RESET_OLD     = 15'd5000;
   localparam logic [14:0] GAS_RESET_BERLIN  = 15'd2900;
   localparam logic [14:0] GAS_SLOAD_OLD     = 15'd800;
   localparam logic [14:0] GAS_SLOAD_BERLIN  = 15'd100;
   localparam logic [14:0] GAS_COLD_SURCHARGE = 15'd2100;
   localparam logic [14:0] REFUND_CLEAR_OLD  = 15'd15000;
   localparam logic [14:0] REFUND_CLEAR_LONDON = 15'd4800;

endpackage

[design/swgm_cost_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swgm_cost_decide
// Cost and signed refund from the accumulated flags of one storage write.
// ----------------------------------------------------------------------------
module swgm_cost_decide (
   input  swgm_pkg::era_type   fork_era,
   input  swgm_pkg::flags_type flags,
   input  logic                cold_slot,
   output logic [14:0]         gas_cost,
   output logic [15:0]         refund_delta
);

   logic        cz, oz, nz;
   logic        c_eq_n, o_eq_c, o_eq_n;
   logic        berlin;
   logic [14:0] s_gas;
   logic [14:0] rst_gas;
   logic [14:0] r_gas;
   logic [14:0] write_cost;
   logic [16:0] refund;

   assign cz     = flags.zero[0];
   assign oz     = flags.zero[1];
   assign nz     = flags.zero[2];
   assign c_eq_n = flags.equal[0];
   assign o_eq_c = flags.equal[1];
   assign o_eq_n = flags.equal[2];

   // per-era amounts
   always_comb begin
      unique case (fork_era)
         swgm_pkg::ERA_PRE_ISTANBUL, swgm_pkg::ERA_ISTANBUL: begin
            berlin  = 1'b0;
            s_gas   = swgm_pkg::GAS_SLOAD_OLD;
            rst_gas = swgm_pkg::GAS_RESET_OLD;
            r_gas   = swgm_pkg::REFUND_CLEAR_OLD;
         end
         swgm_pkg::ERA_BERLIN: begin
            berlin  = 1'b1;
            s_gas   = swgm_pkg::GAS_SLOAD_BERLIN;
            rst_gas = swgm_pkg::GAS_RESET_BERLIN;
            r_gas   = swgm_pkg::REFUND_CLEAR_OLD;
         end
         swgm_pkg::ERA_LONDON: begin
            berlin  = 1'b1;
            s_gas   = swgm_pkg::GAS_SLOAD_BERLIN;
            rst_gas = swgm_pkg::GAS_RESET_BERLIN;
            r_gas   = swgm_pkg::REFUND_CLEAR_LONDON;
         end
         default: begin
            berlin  = 1'b0;
            s_gas   = swgm_pkg::GAS_SLOAD_OLD;
            rst_gas = swgm_pkg::GAS_RESET_OLD;
            r_gas   = swgm_pkg::REFUND_CLEAR_OLD;
         end
      endcase
   end

   // net metering decision, refund kept modulo 2^17 then truncated
   always_comb begin
      refund = 17'd0;
      if (fork_era == swgm_pkg::ERA_PRE_ISTANBUL) begin
         write_cost = (cz && !nz) ? swgm_pkg::GAS_SET : swgm_pkg::GAS_RESET_OLD;
         if (!cz && nz) begin
            refund = {2'b00, swgm_pkg::REFUND_CLEAR_OLD};
         end
      end else begin
         priority if (c_eq_n) begin
            // no-op write
            write_cost = s_gas;
         end else if (o_eq_c) begin
            // first write in this transaction
            write_cost = oz ? swgm_pkg::GAS_SET : rst_gas;
            if (!oz && nz) begin
               refund = {2'b00, r_gas};
            end
         end else begin
            // dirty write
            write_cost = s_gas;
            if (!oz) begin
               if (cz) begin
                  refund = refund - {2'b00, r_gas};
               end
               if (nz) begin
                  refund = refund + {2'b00, r_gas};
               end
            end
            if (o_eq_n) begin
               if (oz) begin
                  refund = refund + {2'b00, swgm_pkg::GAS_SET} - {2'b00, s_gas};
               end else begin
                  refund = refund + {2'b00, rst_gas} - {2'b00, s_gas};
               end
            end
         end
      end
   end

   // cold slot surcharge from berlin on
   assign gas_cost     = (berlin && cold_slot) ? write_cost + swgm_pkg::GAS_COLD_SURCHARGE
                                               : write_cost;
   assign refund_delta = refund[15:0];

endmodule

[design/storage_write_gas_meter_core.sv]
`timescale 1ns / 1ps
// A limb marked last passes the input register and then the result register, which raises rsp_tvalid.
// Throughput: one limb per cycle; the input register and the result register
// overlap, so limbs keep flowing while a finished result waits on rsp, until
// the next closing limb reaches the input register.
// Reset: fork_era returns to London rules, zero and equality flags to all ones,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// storage_write_gas_meter_core
// SSTORE gas meter: per-limb compare, flag accumulation, cost and refund.
// ----------------------------------------------------------------------------
module storage_write_gas_meter_core (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wen,
   input  logic [1:0]   csr_wdata,     // fork_era
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,     // current_limb, original_limb, new_limb
   input  logic         req_tuser,     // cold_slot
   input  logic         req_tlast,     // last_limb
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata      // gas_cost[14:0], refund_delta[30:15], zero pad
);

   swgm_pkg::era_type   fork_era_ff;
   logic                s1_valid_ff;
   swgm_pkg::flags_type s1_flags_ff;
   swgm_pkg::flags_type s1_flags_in;
   logic                s1_cold_ff;
   logic                s1_last_ff;
   logic [2:0]          acc_zero_ff;
   logic [2:0]          acc_equal_ff;
   swgm_pkg::flags_type merged;
   logic                rsp_valid_ff;
   logic [14:0]         cost_ff;
   logic [15:0]         refund_ff;
   logic [14:0]         cost_in;
   logic [15:0]         refund_in;
   logic                out_free;
   logic                s1_adv;
   logic [63:0]         cur_limb, org_limb, new_limb;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         fork_era_ff <= swgm_pkg::ERA_LONDON;
      end else if (csr_wen) begin
         fork_era_ff <= swgm_pkg::era_type'(csr_wdata);
      end
   end

   // per-limb compares ahead of the input register
   assign cur_limb = req_tdata[63:0];
   assign org_limb = req_tdata[127:64];
   assign new_limb = req_tdata[191:128];

   always_comb begin
      s1_flags_in.zero[0]  = (cur_limb == 64'd0);
      s1_flags_in.zero[1]  = (org_limb == 64'd0);
      s1_flags_in.zero[2]  = (new_limb == 64'd0);
      s1_flags_in.equal[0] = (cur_limb == new_limb);
      s1_flags_in.equal[1] = (org_limb == cur_limb);
      s1_flags_in.equal[2] = (org_limb == new_limb);
   end

   // pipeline flow control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_flags_ff <= s1_flags_in;
         s1_cold_ff  <= req_tuser;
         s1_last_ff  <= req_tlast;
      end
   end

   // flags of this limb folded into the running flags
   assign merged.zero  = acc_zero_ff & s1_flags_ff.zero;
   assign merged.equal = acc_equal_ff & s1_flags_ff.equal;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_zero_ff  <= swgm_pkg::FLAGS_ALL;
         acc_equal_ff <= swgm_pkg::FLAGS_ALL;
      end else if (s1_adv) begin
         if (s1_last_ff) begin
            acc_zero_ff  <= swgm_pkg::FLAGS_ALL;
            acc_equal_ff <= swgm_pkg::FLAGS_ALL;
         end else begin
            acc_zero_ff  <= merged.zero;
            acc_equal_ff <= merged.equal;
         end
      end
   end

   // cost and refund
   swgm_cost_decide u_decide (
      .fork_era     (fork_era_ff),
      .flags        (merged),
      .cold_slot    (s1_cold_ff),
      .gas_cost     (cost_in),
      .refund_delta (refund_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         cost_ff   <= cost_in;
         refund_ff <= refund_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, refund_ff, cost_ff};

   // a closing limb always produces a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> rsp_valid_ff)
      else $error("closing limb did not produce a result");

   // running flags restart after a closing limb
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=>
         (acc_zero_ff == swgm_pkg::FLAGS_ALL && acc_equal_ff == swgm_pkg::FLAGS_ALL))
      else $error("flags not restarted after closing limb");

   // input stalls only behind a closing limb blocked by a held result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a blocked result");

   // every result charges at least the cheapest access
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cost_ff >= swgm_pkg::GAS_SLOAD_BERLIN))
      else $error("result cost below minimum");

endmodule
